// ===== sv/fbpr_pkg.sv =====
// Package for the flat-bottom position restraint pipeline.
// Holds widths, register indexes, transaction types and pipeline carry types.
// No dependencies.
package fbpr_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int ATOM_INDEX_BITS = 16;

   localparam int IDX_W      = 16;
   localparam int COORD_W    = 32;
   localparam int EN_W       = 48;
   localparam int KM_W       = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_ATOM = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REF_X       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REF_Y       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REF_Z       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DISP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_K     = 3'd5;

   localparam int DX_W     = COORD_W + 1;
   localparam int SQ_W     = 2 * DX_W - 1;
   localparam int SUM_W    = SQ_W + 1;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int SQ_STEPS = ROOT_W;
   localparam int REM_W    = ROOT_W + 2;
   localparam int TRIAL_W  = REM_W + 2;
   localparam int EE_W     = 2 * ROOT_W;
   localparam int HALF_EE  = EE_W / 2;
   localparam int ENP_W    = HALF_EE + KM_W;
   localparam int KE_W     = KM_W + ROOT_W;
   localparam int HALF_KE  = KE_W / 2;
   localparam int PP_W     = HALF_KE + DX_W;
   localparam int NUM_W    = 98;
   localparam int DEN_W    = ROOT_W + FRAC_BITS;
   localparam int QB       = 41;
   localparam int EN_SHIFT = 2 * FRAC_BITS + 1;
   localparam int ENS_W    = NUM_W - EN_SHIFT;
   localparam int G_W      = QB + 2;

   typedef struct packed {
      logic [IDX_W-1:0]          atom_index;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] grad_in_x;
      logic signed [COORD_W-1:0] grad_in_y;
      logic signed [COORD_W-1:0] grad_in_z;
   } req_type;

   typedef struct packed {
      logic [EN_W-1:0]           energy;
      logic signed [COORD_W-1:0] grad_out_x;
      logic signed [COORD_W-1:0] grad_out_y;
      logic signed [COORD_W-1:0] grad_out_z;
      logic                      restraint_active;
   } rsp_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] grad;
      logic [2:0]              neg;
      logic [2:0][DX_W-1:0]    mag;
      logic                    match;
   } head_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] grad;
      logic [2:0]              neg;
      logic                    active;
      logic [EN_W-1:0]         energy;
   } tail_type;

endpackage

// ===== sv/flat_bottom_position_restraint.sv =====
// Flat-bottom harmonic position restraint, fully pipelined.
// Path: stages A, B and C, the square root, P1 to P4, the divider, then the rsp_strobe register.
// Throughput: one transaction per cycle; busy stays low, the 33-stage square root
// and 41-stage divider each retire one step per stage.
// Reset: synchronous; clears valid bits and all configuration registers to zero.
// Depends on fbpr_pkg.
module flat_bottom_position_restraint #(
   parameter int ATOM_INDEX_BITS = fbpr_pkg::ATOM_INDEX_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fbpr_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [fbpr_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [fbpr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_strobe,
   output fbpr_pkg::rsp_type                   rsp_data
);

   localparam int CMP_W = (ATOM_INDEX_BITS < fbpr_pkg::IDX_W) ?
                          ATOM_INDEX_BITS : fbpr_pkg::IDX_W;
   localparam int SQN   = fbpr_pkg::SQ_STEPS;
   localparam int QB    = fbpr_pkg::QB;

   logic [fbpr_pkg::IDX_W-1:0]          target_ff;
   logic signed [fbpr_pkg::COORD_W-1:0] ref_ff [3];
   logic [fbpr_pkg::KM_W-1:0]           maxd_ff;
   logic [fbpr_pkg::KM_W-1:0]           forcek_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         ref_ff[0] <= '0;
         ref_ff[1] <= '0;
         ref_ff[2] <= '0;
         maxd_ff   <= '0;
         forcek_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            fbpr_pkg::REG_TARGET_ATOM: target_ff <= csr_wdata[fbpr_pkg::IDX_W-1:0];
            fbpr_pkg::REG_REF_X:       ref_ff[0] <= csr_wdata;
            fbpr_pkg::REG_REF_Y:       ref_ff[1] <= csr_wdata;
            fbpr_pkg::REG_REF_Z:       ref_ff[2] <= csr_wdata;
            fbpr_pkg::REG_MAX_DISP:    maxd_ff   <= csr_wdata[fbpr_pkg::KM_W-1:0];
            fbpr_pkg::REG_FORCE_K:     forcek_ff <= csr_wdata[fbpr_pkg::KM_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic acc;
   logic signed [fbpr_pkg::COORD_W-1:0] pos_w [3];
   logic [2:0][fbpr_pkg::COORD_W-1:0]   gin_w;

   assign acc      = start & ~busy;
   assign pos_w[0] = req_data.pos_x;
   assign pos_w[1] = req_data.pos_y;
   assign pos_w[2] = req_data.pos_z;
   assign gin_w    = {req_data.grad_in_z, req_data.grad_in_y, req_data.grad_in_x};

   // stage A: difference from reference, index match
   logic                                a_vld_ff;
   logic signed [fbpr_pkg::DX_W-1:0]    a_dx_ff [3];
   logic [2:0][fbpr_pkg::COORD_W-1:0]   a_grad_ff;
   logic                                a_match_ff;
   // stage B: magnitude and sign
   logic                                b_vld_ff;
   logic [fbpr_pkg::DX_W-1:0]           b_mag_ff [3];
   logic [2:0]                          b_neg_ff;
   logic [2:0][fbpr_pkg::COORD_W-1:0]   b_grad_ff;
   logic                                b_match_ff;
   // stage C: squares
   logic                                c_vld_ff;
   logic [fbpr_pkg::SQ_W-1:0]           c_sq_ff [3];
   fbpr_pkg::head_type                  c_h_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_dx_ff[i]  <= $signed({pos_w[i][fbpr_pkg::COORD_W-1], pos_w[i]}) -
                        $signed({ref_ff[i][fbpr_pkg::COORD_W-1], ref_ff[i]});
         b_neg_ff[i] <= a_dx_ff[i][fbpr_pkg::DX_W-1];
         b_mag_ff[i] <= a_dx_ff[i][fbpr_pkg::DX_W-1] ?
                        fbpr_pkg::DX_W'(-a_dx_ff[i]) : fbpr_pkg::DX_W'(a_dx_ff[i]);
         c_sq_ff[i]  <= fbpr_pkg::SQ_W'(b_mag_ff[i]) * fbpr_pkg::SQ_W'(b_mag_ff[i]);
         c_h_ff.mag[i] <= b_mag_ff[i];
      end
      a_grad_ff   <= gin_w;
      a_match_ff  <= req_data.atom_index[CMP_W-1:0] == target_ff[CMP_W-1:0];
      b_grad_ff   <= a_grad_ff;
      b_match_ff  <= a_match_ff;
      c_h_ff.grad  <= b_grad_ff;
      c_h_ff.neg   <= b_neg_ff;
      c_h_ff.match <= b_match_ff;
   end

   // square root, one result bit per stage
   logic                               sr_vld_ff  [SQN+1];
   logic [fbpr_pkg::SUM_W-1:0]         sr_rad_ff  [SQN+1];
   logic [fbpr_pkg::REM_W-1:0]         sr_rem_ff  [SQN+1];
   logic [fbpr_pkg::ROOT_W-1:0]        sr_root_ff [SQN+1];
   fbpr_pkg::head_type                 sr_h_ff    [SQN+1];
   logic [fbpr_pkg::REM_W-1:0]         sr_rem_in  [SQN];
   logic [fbpr_pkg::ROOT_W-1:0]        sr_root_in [SQN];

   always_comb begin
      logic [fbpr_pkg::TRIAL_W-1:0] rem_t;
      logic [fbpr_pkg::TRIAL_W-1:0] trial;
      for (int s = 0; s < SQN; s++) begin
         rem_t = {sr_rem_ff[s], sr_rad_ff[s][fbpr_pkg::SUM_W-1 -: 2]};
         trial = {2'b00, sr_root_ff[s], 2'b01};
         if (rem_t >= trial) begin
            sr_rem_in[s]  = fbpr_pkg::REM_W'(rem_t - trial);
            sr_root_in[s] = {sr_root_ff[s][fbpr_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            sr_rem_in[s]  = fbpr_pkg::REM_W'(rem_t);
            sr_root_in[s] = {sr_root_ff[s][fbpr_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      sr_rad_ff[0]  <= fbpr_pkg::SUM_W'(c_sq_ff[0]) + fbpr_pkg::SUM_W'(c_sq_ff[1]) +
                       fbpr_pkg::SUM_W'(c_sq_ff[2]);
      sr_rem_ff[0]  <= '0;
      sr_root_ff[0] <= '0;
      sr_h_ff[0]    <= c_h_ff;
      for (int s = 0; s < SQN; s++) begin
         sr_rad_ff[s+1]  <= {sr_rad_ff[s][fbpr_pkg::SUM_W-3:0], 2'b00};
         sr_rem_ff[s+1]  <= sr_rem_in[s];
         sr_root_ff[s+1] <= sr_root_in[s];
         sr_h_ff[s+1]    <= sr_h_ff[s];
      end
   end

   // P1: excess distance
   logic                              p1_vld_ff, p1_active_ff;
   logic [fbpr_pkg::ROOT_W-1:0]       p1_d_ff, p1_e_ff;
   fbpr_pkg::head_type                p1_h_ff;
   // P2: e squared, k times e
   logic                              p2_vld_ff, p2_active_ff;
   logic [fbpr_pkg::EE_W-1:0]         p2_ee_ff;
   logic [fbpr_pkg::KE_W-1:0]         p2_ke_ff;
   logic [fbpr_pkg::DEN_W-1:0]        p2_den_ff;
   fbpr_pkg::head_type                p2_h_ff;
   // P3: partial products
   logic                              p3_vld_ff, p3_active_ff;
   logic [fbpr_pkg::ENP_W-1:0]        p3_enlo_ff, p3_enhi_ff;
   logic [fbpr_pkg::PP_W-1:0]         p3_pl_ff [3];
   logic [fbpr_pkg::PP_W-1:0]         p3_ph_ff [3];
   logic [fbpr_pkg::DEN_W-1:0]        p3_den_ff;
   fbpr_pkg::head_type                p3_h_ff;
   // P4: sums with rounding
   logic                              p4_vld_ff, p4_active_ff;
   logic [fbpr_pkg::NUM_W-1:0]        p4_en_ff;
   logic [fbpr_pkg::NUM_W-1:0]        p4_num_ff [3];
   logic [fbpr_pkg::DEN_W-1:0]        p4_den_ff;
   fbpr_pkg::head_type                p4_h_ff;

   always_ff @(posedge clock) begin
      p1_d_ff      <= sr_root_ff[SQN];
      p1_active_ff <= sr_h_ff[SQN].match &&
                      (sr_root_ff[SQN] > fbpr_pkg::ROOT_W'(maxd_ff));
      p1_e_ff      <= sr_root_ff[SQN] - fbpr_pkg::ROOT_W'(maxd_ff);
      p1_h_ff      <= sr_h_ff[SQN];

      p2_ee_ff     <= fbpr_pkg::EE_W'(p1_e_ff) * fbpr_pkg::EE_W'(p1_e_ff);
      p2_ke_ff     <= fbpr_pkg::KE_W'(forcek_ff) * fbpr_pkg::KE_W'(p1_e_ff);
      p2_den_ff    <= {p1_d_ff, {fbpr_pkg::FRAC_BITS{1'b0}}};
      p2_active_ff <= p1_active_ff;
      p2_h_ff      <= p1_h_ff;

      p3_enlo_ff   <= fbpr_pkg::ENP_W'(p2_ee_ff[fbpr_pkg::HALF_EE-1:0]) *
                      fbpr_pkg::ENP_W'(forcek_ff);
      p3_enhi_ff   <= fbpr_pkg::ENP_W'(p2_ee_ff[fbpr_pkg::EE_W-1:fbpr_pkg::HALF_EE]) *
                      fbpr_pkg::ENP_W'(forcek_ff);
      for (int i = 0; i < 3; i++) begin
         p3_pl_ff[i] <= fbpr_pkg::PP_W'(p2_ke_ff[fbpr_pkg::HALF_KE-1:0]) *
                        fbpr_pkg::PP_W'(p2_h_ff.mag[i]);
         p3_ph_ff[i] <= fbpr_pkg::PP_W'(p2_ke_ff[fbpr_pkg::KE_W-1:fbpr_pkg::HALF_KE]) *
                        fbpr_pkg::PP_W'(p2_h_ff.mag[i]);
         p4_num_ff[i] <= fbpr_pkg::NUM_W'(p3_pl_ff[i]) +
                         (fbpr_pkg::NUM_W'(p3_ph_ff[i]) << fbpr_pkg::HALF_KE) +
                         fbpr_pkg::NUM_W'(p3_den_ff >> 1);
      end
      p3_den_ff    <= p2_den_ff;
      p3_active_ff <= p2_active_ff;
      p3_h_ff      <= p2_h_ff;

      p4_en_ff     <= fbpr_pkg::NUM_W'(p3_enlo_ff) +
                      (fbpr_pkg::NUM_W'(p3_enhi_ff) << fbpr_pkg::HALF_EE) +
                      (fbpr_pkg::NUM_W'(1) << (2 * fbpr_pkg::FRAC_BITS));
      p4_den_ff    <= p3_den_ff;
      p4_active_ff <= p3_active_ff;
      p4_h_ff      <= p3_h_ff;
   end

   // divider, one quotient bit per stage
   logic                              dv_vld_ff  [QB+1];
   logic [fbpr_pkg::DEN_W-1:0]        dv_rem_ff  [QB+1][3];
   logic [QB-1:0]                     dv_low_ff  [QB+1][3];
   logic [2:0]                        dv_cap_ff  [QB+1];
   logic [fbpr_pkg::DEN_W-1:0]        dv_den_ff  [QB+1];
   fbpr_pkg::tail_type                dv_t_ff    [QB+1];
   logic [fbpr_pkg::DEN_W-1:0]        dv_rem_in  [QB][3];
   logic [QB-1:0]                     dv_low_in  [QB][3];

   logic [fbpr_pkg::ENS_W-1:0]        en_sh;
   logic [fbpr_pkg::EN_W-1:0]         en_sat;
   logic [2:0]                        cap0;

   always_comb begin
      en_sh  = p4_en_ff[fbpr_pkg::NUM_W-1:fbpr_pkg::EN_SHIFT];
      en_sat = (|en_sh[fbpr_pkg::ENS_W-1:fbpr_pkg::EN_W]) ?
               {fbpr_pkg::EN_W{1'b1}} : en_sh[fbpr_pkg::EN_W-1:0];
      for (int i = 0; i < 3; i++) begin
         cap0[i] = p4_num_ff[i] >= (fbpr_pkg::NUM_W'(p4_den_ff) << QB);
      end
   end

   always_comb begin
      logic [fbpr_pkg::DEN_W:0] t;
      for (int s = 0; s < QB; s++) begin
         for (int i = 0; i < 3; i++) begin
            t = {dv_rem_ff[s][i], dv_low_ff[s][i][QB-1]};
            if (t >= {1'b0, dv_den_ff[s]}) begin
               dv_rem_in[s][i] = fbpr_pkg::DEN_W'(t - {1'b0, dv_den_ff[s]});
               dv_low_in[s][i] = {dv_low_ff[s][i][QB-2:0], 1'b1};
            end else begin
               dv_rem_in[s][i] = t[fbpr_pkg::DEN_W-1:0];
               dv_low_in[s][i] = {dv_low_ff[s][i][QB-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dv_rem_ff[0][i] <= cap0[i] ? '0 : p4_num_ff[i][QB +: fbpr_pkg::DEN_W];
         dv_low_ff[0][i] <= p4_num_ff[i][QB-1:0];
      end
      dv_cap_ff[0]        <= cap0;
      dv_den_ff[0]        <= p4_den_ff;
      dv_t_ff[0].grad     <= p4_h_ff.grad;
      dv_t_ff[0].neg      <= p4_h_ff.neg;
      dv_t_ff[0].active   <= p4_active_ff;
      dv_t_ff[0].energy   <= p4_active_ff ? en_sat : '0;
      for (int s = 0; s < QB; s++) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[s+1][i] <= dv_rem_in[s][i];
            dv_low_ff[s+1][i] <= dv_low_in[s][i];
         end
         dv_cap_ff[s+1] <= dv_cap_ff[s];
         dv_den_ff[s+1] <= dv_den_ff[s];
         dv_t_ff[s+1]   <= dv_t_ff[s];
      end
   end

   // final: cap term, add to gradient, saturate
   localparam logic [QB-1:0] TERM_CAP = QB'(1) << (QB - 1);

   logic [2:0][fbpr_pkg::COORD_W-1:0] gout;

   always_comb begin
      logic [QB-1:0]                 term;
      logic signed [fbpr_pkg::G_W-1:0] g;
      logic [fbpr_pkg::G_W-fbpr_pkg::COORD_W:0] top;
      for (int i = 0; i < 3; i++) begin
         if (!dv_t_ff[QB].active) begin
            term = '0;
         end else if (dv_cap_ff[QB][i] || (dv_low_ff[QB][i] > TERM_CAP)) begin
            term = TERM_CAP;
         end else begin
            term = dv_low_ff[QB][i];
         end
         g = fbpr_pkg::G_W'($signed(dv_t_ff[QB].grad[i]));
         if (dv_t_ff[QB].neg[i]) begin
            g = g - $signed({2'b00, term});
         end else begin
            g = g + $signed({2'b00, term});
         end
         top = g[fbpr_pkg::G_W-1:fbpr_pkg::COORD_W-1];
         if ((&top) || !(|top)) begin
            gout[i] = g[fbpr_pkg::COORD_W-1:0];
         end else begin
            gout[i] = g[fbpr_pkg::G_W-1] ? {1'b1, {(fbpr_pkg::COORD_W-1){1'b0}}} :
                                           {1'b0, {(fbpr_pkg::COORD_W-1){1'b1}}};
         end
      end
   end

   logic              rsp_strobe_ff;
   fbpr_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      rsp_data_ff.energy           <= dv_t_ff[QB].energy;
      rsp_data_ff.grad_out_x       <= gout[0];
      rsp_data_ff.grad_out_y       <= gout[1];
      rsp_data_ff.grad_out_z       <= gout[2];
      rsp_data_ff.restraint_active <= dv_t_ff[QB].active;
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int s = 0; s <= SQN; s++) begin
            sr_vld_ff[s] <= 1'b0;
         end
         for (int s = 0; s <= QB; s++) begin
            dv_vld_ff[s] <= 1'b0;
         end
      end else begin
         a_vld_ff     <= acc;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         sr_vld_ff[0] <= c_vld_ff;
         for (int s = 0; s < SQN; s++) begin
            sr_vld_ff[s+1] <= sr_vld_ff[s];
         end
         p1_vld_ff    <= sr_vld_ff[SQN];
         p2_vld_ff    <= p1_vld_ff;
         p3_vld_ff    <= p2_vld_ff;
         p4_vld_ff    <= p3_vld_ff;
         dv_vld_ff[0] <= p4_vld_ff;
         for (int s = 0; s < QB; s++) begin
            dv_vld_ff[s+1] <= dv_vld_ff[s];
         end
         rsp_strobe_ff <= dv_vld_ff[QB];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== test/tb_flat_bottom_position_restraint.sv =====
// Testbench for the flat-bottom position restraint pipeline: directed table, then random phases.
// Every response is checked field by field against a built-in restraint predictor or a typed table.
// Depends on fbpr_pkg and flat_bottom_position_restraint.
module tb_flat_bottom_position_restraint;
   timeunit 1ns;
   timeprecision 1ps;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   fbpr_pkg::req_type               req_data = '0;
   logic                            csr_we = 1'b0;
   logic [fbpr_pkg::CSR_IDX_W-1:0]  csr_idx = '0;
   logic [fbpr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            rsp_strobe;
   fbpr_pkg::rsp_type               rsp_data;

   flat_bottom_position_restraint i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [fbpr_pkg::IDX_W-1:0] target_atom;
   logic [2:0][31:0]           ref_pos;
   logic [fbpr_pkg::KM_W-1:0]  max_disp;
   logic [fbpr_pkg::KM_W-1:0]  force_k;
   fbpr_pkg::rsp_type          expected_responses[$];
   int                         mismatches = 0;
   bit                         quiet_phase = 0;

   function automatic fbpr_pkg::rsp_type predict_restraint(fbpr_pkg::req_type r);
      fbpr_pkg::rsp_type o;
      logic [2:0][31:0] pos, gin;
      longint           dx[3];
      logic [65:0]      sum;
      logic [67:0]      rem, root, trial;
      logic [127:0]     mag[3];
      logic [127:0]     en, den, num, q;
      longint           g, d, e;
      pos = {r.pos_z, r.pos_y, r.pos_x};
      gin = {r.grad_in_z, r.grad_in_y, r.grad_in_x};
      o.energy = '0;
      o.restraint_active = 1'b0;
      o.grad_out_x = r.grad_in_x;
      o.grad_out_y = r.grad_in_y;
      o.grad_out_z = r.grad_in_z;
      if (r.atom_index != target_atom) return o;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         dx[i] = longint'($signed(pos[i])) - longint'($signed(ref_pos[i]));
         mag[i] = 128'(dx[i] < 0 ? -dx[i] : dx[i]);
         sum += 66'(mag[i] * mag[i]);
      end
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | 68'(sum[2*i +: 2]);
         trial = (root << 2) | 68'd1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 68'd1;
         end else begin
            root = root << 1;
         end
      end
      d = longint'(root);
      if (d <= longint'(max_disp)) return o;
      e = d - longint'(max_disp);
      en = ((128'(force_k) * 128'(e) * 128'(e)) + (128'd1 << 32)) >> 33;
      o.energy = (en > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : en[47:0];
      den = 128'(d) << fbpr_pkg::FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         num = 128'(force_k) * 128'(e) * mag[i] + (den >> 1);
         q = num / den;
         if (q > (128'd1 << 40)) q = 128'd1 << 40;
         g = dx[i] < 0 ? longint'($signed(gin[i])) - longint'(q)
                        : longint'($signed(gin[i])) + longint'(q);
         if (g > 64'sd2147483647) g = 64'sd2147483647;
         if (g < -64'sd2147483648) g = -64'sd2147483648;
         case (i)
            0: o.grad_out_x = g[31:0];
            1: o.grad_out_y = g[31:0];
            default: o.grad_out_z = g[31:0];
         endcase
      end
      o.restraint_active = 1'b1;
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch %s: got %h, want %h at %0t", field, got, want, $realtime);
   endtask

   always @(posedge clock) begin
      fbpr_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_data.energy), 64'd0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_data.energy !== want.energy)
               report_mismatch("energy", 64'(rsp_data.energy), 64'(want.energy));
            if (rsp_data.grad_out_x !== want.grad_out_x)
               report_mismatch("grad_out_x", 64'(rsp_data.grad_out_x), 64'(want.grad_out_x));
            if (rsp_data.grad_out_y !== want.grad_out_y)
               report_mismatch("grad_out_y", 64'(rsp_data.grad_out_y), 64'(want.grad_out_y));
            if (rsp_data.grad_out_z !== want.grad_out_z)
               report_mismatch("grad_out_z", 64'(rsp_data.grad_out_z), 64'(want.grad_out_z));
            if (rsp_data.restraint_active !== want.restraint_active)
               report_mismatch("restraint_active", 64'(rsp_data.restraint_active),
                               64'(want.restraint_active));
         end
      end
   end

   task automatic drain;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [fbpr_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         fbpr_pkg::REG_TARGET_ATOM: target_atom = value[fbpr_pkg::IDX_W-1:0];
         fbpr_pkg::REG_REF_X:       ref_pos[0] = value;
         fbpr_pkg::REG_REF_Y:       ref_pos[1] = value;
         fbpr_pkg::REG_REF_Z:       ref_pos[2] = value;
         fbpr_pkg::REG_MAX_DISP:    max_disp = value[fbpr_pkg::KM_W-1:0];
         fbpr_pkg::REG_FORCE_K:     force_k = value[fbpr_pkg::KM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_config(logic [15:0] tgt, logic [31:0] rx, logic [31:0] ry,
                              logic [31:0] rz, logic [30:0] m, logic [30:0] k);
      drain();
      write_reg(fbpr_pkg::REG_TARGET_ATOM, 32'(tgt));
      write_reg(fbpr_pkg::REG_REF_X, rx);
      write_reg(fbpr_pkg::REG_REF_Y, ry);
      write_reg(fbpr_pkg::REG_REF_Z, rz);
      write_reg(fbpr_pkg::REG_MAX_DISP, 32'(m));
      write_reg(fbpr_pkg::REG_FORCE_K, 32'(k));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send(fbpr_pkg::req_type item, bit typed, fbpr_pkg::rsp_type typed_rsp);
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_responses.push_back(typed ? typed_rsp : predict_restraint(item));
      if (!quiet_phase && $urandom_range(99) < 19) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] near(logic [31:0] center);
      case ($urandom_range(3))
         0: return $urandom();
         1: return center + 32'($signed($urandom_range(0, 2000)) - 1000);
         2: return center + 32'($signed($urandom_range(0, 4000000)) - 2000000);
         default: return center + ($urandom() >>> 6) - 32'h0200_0000;
      endcase
   endfunction

   fbpr_pkg::req_type directed_reset[4];
   fbpr_pkg::rsp_type directed_reset_rsp[4];
   fbpr_pkg::req_type directed_edge[6];
   fbpr_pkg::rsp_type dummy;
   fbpr_pkg::req_type item;

   initial begin
      dummy = '0;
      target_atom = '0;
      ref_pos = '0;
      max_disp = '0;
      force_k = '0;
      directed_reset[0] = '{16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      directed_reset_rsp[0] = '{48'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0};
      directed_reset[1] = '{16'd0, 32'd0, 32'd0, 32'd0, 32'd7, 32'd8, 32'd9};
      directed_reset_rsp[1] = '{48'd0, 32'd7, 32'd8, 32'd9, 1'b0};
      directed_reset[2] = '{16'd0, 32'd1, 32'd0, 32'd0, 32'h8000_0000, 32'd3, 32'h7FFF_FFFF};
      directed_reset_rsp[2] = '{48'd0, 32'h8000_0000, 32'd3, 32'h7FFF_FFFF, 1'b1};
      directed_reset[3] = '{16'hFFFF, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1};
      directed_reset_rsp[3] = '{48'd0, 32'd1, 32'd1, 32'd1, 1'b0};
      directed_edge[0] = '{16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      directed_edge[1] = '{16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      directed_edge[2] = '{16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0};
      directed_edge[3] = '{16'hFFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3};
      directed_edge[4] = '{16'hFFFF, 32'h7FFF_FFFE, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0};
      directed_edge[5] = '{16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_reset[i]) send(directed_reset[i], 1'b1, directed_reset_rsp[i]);
      start <= 1'b0;
      load_config(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 31'd0, 31'h7FFF_FFFF);
      foreach (directed_edge[i]) send(directed_edge[i], 1'b0, dummy);
      start <= 1'b0;
      load_config(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      foreach (directed_edge[i]) send(directed_edge[i], 1'b0, dummy);
      start <= 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_config(16'($urandom()), $urandom(), $urandom(), $urandom(),
                           31'($urandom_range(0, 32'h0010_0000)),
                           31'($urandom_range(0, 32'h0004_0000)));
            1: load_config(16'($urandom()), $urandom(), $urandom(), $urandom(),
                           31'($urandom()), 31'($urandom()));
            2: load_config(16'd0, 32'd0, 32'd0, 32'd0, 31'd0, 31'd1);
            3: load_config(16'($urandom()), $urandom(), $urandom(), $urandom(),
                           31'($urandom_range(0, 32'h0200_0000)), 31'h7FFF_FFFF);
            4: load_config(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           31'h7FFF_FFFF, 31'($urandom()));
            default: load_config(16'($urandom()), $urandom(), $urandom(), $urandom(),
                                 31'($urandom_range(0, 32'h0008_0000)),
                                 31'($urandom_range(0, 32'h00FF_FFFF)));
         endcase
         quiet_phase = (phase == 2);
         for (int n = 0; n < 100; n++) begin
            item.atom_index = ($urandom_range(99) < 80) ? target_atom : 16'($urandom());
            item.pos_x = near(ref_pos[0]);
            item.pos_y = near(ref_pos[1]);
            item.pos_z = near(ref_pos[2]);
            item.grad_in_x = $urandom();
            item.grad_in_y = $urandom();
            item.grad_in_z = $urandom();
            send(item, 1'b0, dummy);
         end
         start <= 1'b0;
      end
      quiet_phase = 0;
      drain();
      repeat (90) @(posedge clock);
      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
